// ----- rtl/vrd_pkg.sv -----
// ----------------------------------------------------------------------------
// vrd_pkg: shared types and constants for the vector rotator
// Payload structs, datapath widths, CORDIC arctangent table and gain.
// ----------------------------------------------------------------------------
package vrd_pkg;

    // number of micro-rotations, 8 to 24
    localparam int STAGES = 16;
    localparam int IDX_W  = $clog2(STAGES);

    localparam int XW = 36;   // x, y: Q8.8 << 16 plus sign, negation and gain growth
    localparam int ZW = 32;   // angle in 2^-22 degree units

    localparam int ANGLE_FRAC    = 22;
    localparam int HALF_TURN_DEG = 180;
    localparam logic signed [ZW-1:0] QUARTER_TURN =
        ZW'((HALF_TURN_DEG / 2) * (1 << ANGLE_FRAC));
    localparam logic signed [ZW-1:0] HALF_TURN =
        ZW'(HALF_TURN_DEG * (1 << ANGLE_FRAC));

    // 1/K as Q0.30
    localparam logic [29:0] INV_GAIN = 30'd652032874;

    localparam int ATAN_IW = 5;

    typedef struct packed {
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] turn_angle;
    } vrd_in_t;

    typedef struct packed {
        logic signed [15:0] rot_x;
        logic signed [15:0] rot_y;
        logic               clipped;
    } vrd_out_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } vrd_vec_t;

    // atan(2^-i) in 2^-22 degree units
    function automatic logic signed [ZW-1:0] atan_of(input logic [ATAN_IW-1:0] i);
        logic signed [ZW-1:0] a;
        unique case (i)
            5'd0:    a = 32'sd188743680;
            5'd1:    a = 32'sd111421900;
            5'd2:    a = 32'sd58872272;
            5'd3:    a = 32'sd29884485;
            5'd4:    a = 32'sd15000234;
            5'd5:    a = 32'sd7507429;
            5'd6:    a = 32'sd3754631;
            5'd7:    a = 32'sd1877430;
            5'd8:    a = 32'sd938729;
            5'd9:    a = 32'sd469366;
            5'd10:   a = 32'sd234683;
            5'd11:   a = 32'sd117342;
            5'd12:   a = 32'sd58671;
            5'd13:   a = 32'sd29335;
            5'd14:   a = 32'sd14668;
            5'd15:   a = 32'sd7334;
            5'd16:   a = 32'sd3667;
            5'd17:   a = 32'sd1833;
            5'd18:   a = 32'sd917;
            5'd19:   a = 32'sd458;
            5'd20:   a = 32'sd229;
            5'd21:   a = 32'sd115;
            5'd22:   a = 32'sd57;
            5'd23:   a = 32'sd29;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/vrd_prerot.sv -----
// ----------------------------------------------------------------------------
// vrd_prerot: input widening and half-turn fold
// Brings the angle within +-90 degrees by negating the vector.
// ----------------------------------------------------------------------------
module vrd_prerot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              d_valid,
    input  vrd_pkg::vrd_in_t  d,
    output logic              q_valid,
    output vrd_pkg::vrd_vec_t q
);
    import vrd_pkg::*;

    logic     valid_reg, valid_next;
    vrd_vec_t data_reg, data_next;

    logic signed [XW-1:0] x_w, y_w;
    logic signed [ZW-1:0] z_w;

    always_comb
    begin
        x_w = XW'(d.vec_x) <<< 16;
        y_w = XW'(d.vec_y) <<< 16;
        z_w = ZW'(d.turn_angle) <<< 15;
        data_next = '{x: x_w, y: y_w, z: z_w};
        if (z_w > QUARTER_TURN)
        begin
            data_next = '{x: -x_w, y: -y_w, z: z_w - HALF_TURN};
        end
        else if (z_w < -QUARTER_TURN)
        begin
            data_next = '{x: -x_w, y: -y_w, z: z_w + HALF_TURN};
        end
        valid_next = en ? d_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign q_valid = valid_reg;
    assign q       = data_reg;

endmodule

// ----- rtl/vrd_cell.sv -----
// ----------------------------------------------------------------------------
// vrd_cell: one CORDIC micro-rotation
// Rotates toward zero residual angle by atan(2^-idx), registered.
// ----------------------------------------------------------------------------
module vrd_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [vrd_pkg::IDX_W-1:0] idx,
    input  logic                      d_valid,
    input  vrd_pkg::vrd_vec_t         d,
    output logic                      q_valid,
    output vrd_pkg::vrd_vec_t         q
);
    import vrd_pkg::*;

    logic     valid_reg, valid_next;
    vrd_vec_t data_reg, data_next;

    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] da;

    always_comb
    begin
        dx = d.y >>> idx;
        dy = d.x >>> idx;
        da = atan_of(ATAN_IW'(idx));
        if (!d.z[ZW-1])
            data_next = '{x: d.x - dx, y: d.y + dy, z: d.z - da};
        else
            data_next = '{x: d.x + dx, y: d.y - dy, z: d.z + da};
        valid_next = en ? d_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign q_valid = valid_reg;
    assign q       = data_reg;

endmodule

// ----- rtl/vrd_scale.sv -----
// ----------------------------------------------------------------------------
// vrd_scale: gain removal, rounding and saturation for one component
// Split 18x30 partial products, then round-half-up add, then clamp.
// ----------------------------------------------------------------------------
module vrd_scale (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [vrd_pkg::XW-1:0] v,
    output logic signed [15:0]          r,
    output logic                        sat
);
    import vrd_pkg::*;

    localparam int LO_W  = 18;
    localparam int HI_W  = XW - LO_W;
    localparam int SUM_W = XW + 31;
    localparam int SH    = 46;
    localparam int RW    = SUM_W - SH;

    logic        [LO_W+29:0]  lo_reg, lo_next;
    logic signed [HI_W+30:0]  hi_reg, hi_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [15:0]       r_reg, r_next;
    logic                     sat_reg, sat_next;
    logic signed [RW-1:0]     rs;

    always_comb
    begin
        lo_next  = (LO_W+30)'(v[LO_W-1:0]) * (LO_W+30)'(INV_GAIN);
        hi_next  = (HI_W+31)'($signed(v[XW-1:LO_W])) * (HI_W+31)'($signed({1'b0, INV_GAIN}));
        sum_next = (SUM_W'(hi_reg) <<< LO_W) + $signed(SUM_W'(lo_reg))
                 + (SUM_W'(1) <<< (SH - 1));
        rs = sum_reg[SUM_W-1:SH];
        // clamp when the bits above bit 15 are not a pure sign extension
        if (rs[RW-1:15] != {(RW-15){rs[RW-1]}})
        begin
            sat_next = 1'b1;
            r_next   = rs[RW-1] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            sat_next = 1'b0;
            r_next   = rs[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            sum_reg <= sum_next;
            r_reg   <= r_next;
            sat_reg <= sat_next;
        end
    end

    assign r   = r_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/vector_rotate_degrees.sv -----
// ----------------------------------------------------------------------------
// vector_rotate_degrees: CORDIC rotation of a Q8.8 vector by an angle in degrees
// Fold stage, a chain of micro-rotation cells, gain scale and saturation.
// ----------------------------------------------------------------------------
// Pipeline order: fold, the chain of micro-rotation cells, multiply, round,
//   clamp into the output register.
// Throughput: one transfer per cycle; the whole pipe advances together and
//   only halts while a finished result waits on rot_ready.
// Reset: rst_n clears all valid bits; data registers are not reset.
module vector_rotate_degrees (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vec_valid,
    output logic               vec_ready,
    input  vrd_pkg::vrd_in_t   vec,
    output logic               rot_valid,
    input  logic               rot_ready,
    output vrd_pkg::vrd_out_t  rot
);
    import vrd_pkg::*;

    localparam int TAIL = 3;

    logic en;
    logic pre_valid;
    vrd_vec_t pre_data;

    logic     [STAGES-1:0] cell_valid;
    vrd_vec_t              cell_data [STAGES];

    logic [TAIL-1:0] tail_valid_reg, tail_valid_next;
    logic signed [15:0] rx, ry;
    logic sat_x, sat_y;

    assign en        = !rot_valid || rot_ready;
    assign vec_ready = en;

    vrd_prerot u_prerot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .d_valid (vec_valid),
        .d       (vec),
        .q_valid (pre_valid),
        .q       (pre_data)
    );

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        localparam logic [IDX_W-1:0] IDX = IDX_W'(i);
        if (i == 0)
        begin : g_first
            vrd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .idx     (IDX),
                .d_valid (pre_valid),
                .d       (pre_data),
                .q_valid (cell_valid[i]),
                .q       (cell_data[i])
            );
        end
        else
        begin : g_next
            vrd_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .idx     (IDX),
                .d_valid (cell_valid[i-1]),
                .d       (cell_data[i-1]),
                .q_valid (cell_valid[i]),
                .q       (cell_data[i])
            );
        end
    end

    vrd_scale u_scale_x (
        .clk (clk),
        .en  (en),
        .v   (cell_data[STAGES-1].x),
        .r   (rx),
        .sat (sat_x)
    );

    vrd_scale u_scale_y (
        .clk (clk),
        .en  (en),
        .v   (cell_data[STAGES-1].y),
        .r   (ry),
        .sat (sat_y)
    );

    always_comb
    begin
        tail_valid_next = tail_valid_reg;
        if (en)
            tail_valid_next = {tail_valid_reg[TAIL-2:0], cell_valid[STAGES-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_valid_reg <= '0;
        else
            tail_valid_reg <= tail_valid_next;
    end

    assign rot_valid = tail_valid_reg[TAIL-1];
    assign rot       = '{rot_x: rx, rot_y: ry, clipped: sat_x | sat_y};

    // accepted transfer lands in the fold stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        vec_valid && vec_ready |=> pre_valid)
        else $error("accepted transfer lost at fold stage");

    // a halted pipe keeps every valid bit
    a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(cell_valid) && $stable(tail_valid_reg) && $stable(pre_valid))
        else $error("valid bits moved while halted");

    // last cell feeds the scale stages
    a_tail_enters: assert property (@(posedge clk) disable iff (!rst_n)
        en && cell_valid[STAGES-1] |=> tail_valid_reg[0])
        else $error("item lost between cells and scale");

    // a clipped result sits at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && rot.clipped |->
            rot.rot_x == 16'sh7fff || rot.rot_x == 16'sh8000 ||
            rot.rot_y == 16'sh7fff || rot.rot_y == 16'sh8000)
        else $error("clipped flag without saturated component");

endmodule
